// File: rtl/heightfield_normal_generator_unit_assert.svh
// assertion macros used by the heightfield normal generator controller
`ifndef HEIGHTFIELD_NORMAL_GENERATOR_UNIT_ASSERT_SVH
`define HEIGHTFIELD_NORMAL_GENERATOR_UNIT_ASSERT_SVH
// same-cycle implication
`define HNORM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hnorm assertion failed");
// next-cycle implication
`define HNORM_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hnorm assertion failed");
`endif

// File: rtl/hnorm_pkg.sv
// ----------------------------------------------------------------------------
// hnorm_pkg
// Shared constants, types and codes of the heightfield normal generator.
// ----------------------------------------------------------------------------
package hnorm_pkg;

   // grid and line store sizing
   localparam int MAX_SEGMENTS = 255;
   localparam int STORE_DEPTH  = MAX_SEGMENTS + 1;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int SEG_W        = 8;

   // sample and step widths
   localparam int HEIGHT_BITS  = 16;
   localparam int DIFF_W       = HEIGHT_BITS + 1;
   localparam int MAG_W        = HEIGHT_BITS;
   localparam int STEP_W       = 16;

   // normalizer widths
   localparam int VEC_W        = 2 * STEP_W + 1;
   localparam int WIN_W        = 31;
   localparam int SUM_W        = 64;
   localparam int ROOT_W       = 32;
   localparam int FRAC_W       = 15;
   localparam int NUM_W        = WIN_W + FRAC_W + 1;
   localparam int QUO_W        = 17;
   localparam int NORM_W       = 16;

   // configuration port
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   typedef enum logic [2:0] {
      REG_STEP_X    = 3'd0,
      REG_STEP_Z    = 3'd1,
      REG_SEG_ACR   = 3'd2,
      REG_SEG_DOWN  = 3'd3,
      REG_FLAT_MODE = 3'd4
   } reg_index_type;

   // which of the up to three normals an item causes
   typedef enum logic [1:0] {
      KIND_BELOW  = 2'd0,
      KIND_LEFT   = 2'd1,
      KIND_CORNER = 2'd2
   } kind_type;

   // line store access steps
   typedef enum logic [2:0] {
      STEP_NONE   = 3'd0,
      STEP_READ_A = 3'd1,
      STEP_READ_B = 3'd2,
      STEP_READ_C = 3'd3,
      STEP_COMMIT = 3'd4
   } step_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_x;
      logic [STEP_W-1:0] step_z;
      logic [SEG_W-1:0]  seg_across;
      logic [SEG_W-1:0]  seg_down;
      logic              flat;
   } cfg_type;

   typedef struct packed {
      logic     accept;
      step_type step;
      logic     start;
      kind_type kind;
      logic     load_out;
      logic     last;
      logic     finish;
   } cmd_type;

   typedef struct packed {
      logic e_below;
      logic e_left;
      logic e_corner;
      logic norm_free;
      logic norm_ready;
      logic out_free;
   } sts_type;

endpackage

// File: rtl/heightfield_normal_generator_unit.sv
// ----------------------------------------------------------------------------
// heightfield_normal_generator_unit
// Surface normals from central differences over a raster-order height grid.
// ----------------------------------------------------------------------------
// channel   | ports  | contents
// req       | req_*  | one height sample per item
// rsp       | rsp_*  | up to three normals per item, row behind the input
// csr       | csr_*  | step_x, step_z, segments_across, segments_down, flat_mode
//
// Each sample runs through the line store reads and write-back, then each normal
// through the shared normalizer (scale shift, integer square root, three divides);
// in flat mode the normalizer goes straight to an upright normal.
// Reset is synchronous; line stores are not cleared and are read only where
// written. The result register lets the next sample in while a normal waits.
// ----------------------------------------------------------------------------
module heightfield_normal_generator_unit import hnorm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [HEIGHT_BITS-1:0] req_tdata,    // height_sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // normal_x[15:0], normal_y[30:16], normal_z[46:31], grid_column[54:47],
   // grid_row[62:55], zero[63]
   output logic [63:0]            rsp_tdata,
   output logic                   rsp_tlast,    // last_of_run
   output logic                   rsp_tuser,    // grid_done
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   hnorm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hnorm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   hnorm_path u_path (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: rtl/hnorm_csr.sv
// ----------------------------------------------------------------------------
// hnorm_csr
// Configuration registers behind the register bus port.
// ----------------------------------------------------------------------------
module hnorm_csr import hnorm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [STEP_W-1:0] step_x_ff;
   logic [STEP_W-1:0] step_z_ff;
   logic [SEG_W-1:0]  seg_across_ff;
   logic [SEG_W-1:0]  seg_down_ff;
   logic              flat_ff;
   logic              wr_en;
   reg_index_type     idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff     <= STEP_W'(256);
         step_z_ff     <= STEP_W'(256);
         seg_across_ff <= SEG_W'(64);
         seg_down_ff   <= SEG_W'(64);
         flat_ff       <= 1'b0;
      end else if (wr_en) begin
         unique case (idx)
            REG_STEP_X:    step_x_ff     <= csr_pwdata[STEP_W-1:0];
            REG_STEP_Z:    step_z_ff     <= csr_pwdata[STEP_W-1:0];
            REG_SEG_ACR:   seg_across_ff <= csr_pwdata[SEG_W-1:0];
            REG_SEG_DOWN:  seg_down_ff   <= csr_pwdata[SEG_W-1:0];
            REG_FLAT_MODE: flat_ff       <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_STEP_X:    csr_prdata = CSR_DATA_W'(step_x_ff);
         REG_STEP_Z:    csr_prdata = CSR_DATA_W'(step_z_ff);
         REG_SEG_ACR:   csr_prdata = CSR_DATA_W'(seg_across_ff);
         REG_SEG_DOWN:  csr_prdata = CSR_DATA_W'(seg_down_ff);
         REG_FLAT_MODE: csr_prdata = CSR_DATA_W'(flat_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.step_x     = step_x_ff;
   assign cfg.step_z     = step_z_ff;
   assign cfg.seg_across = seg_across_ff;
   assign cfg.seg_down   = seg_down_ff;
   assign cfg.flat       = flat_ff;

endmodule

// File: rtl/hnorm_unit.sv
// ----------------------------------------------------------------------------
// hnorm_unit
// Iterative normalizer: scales the difference vector, takes an integer
// square root one bit pair per cycle and divides one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hnorm_unit import hnorm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     flat,
   input  logic signed [DIFF_W-1:0] diff_r,
   input  logic signed [DIFF_W-1:0] diff_u,
   input  logic [STEP_W-1:0]        step_x,
   input  logic [STEP_W-1:0]        step_z,
   output logic                     free,
   output logic                     ready,
   output logic signed [NORM_W-1:0] norm_x,
   output logic [NORM_W-2:0]        norm_y,
   output logic signed [NORM_W-1:0] norm_z
);

   typedef enum logic [7:0] {
      U_IDLE   = 8'b0000_0001,
      U_MUL    = 8'b0000_0010,
      U_SHIFT  = 8'b0000_0100,
      U_SQUARE = 8'b0000_1000,
      U_ROOT   = 8'b0001_0000,
      U_DSET   = 8'b0010_0000,
      U_DIV    = 8'b0100_0000,
      U_DONE   = 8'b1000_0000
   } ustate_type;

   ustate_type          state_ff, state_in;
   logic [MAG_W-1:0]    dr_mag_ff, du_mag_ff;
   logic [STEP_W-1:0]   sx_ff, sz_ff;
   logic                neg_x_ff, neg_z_ff;
   logic [VEC_W-1:0]    a_ff, b_ff, c_ff;
   logic [4:0]          cnt_ff;
   logic [1:0]          dk_ff;
   logic [2*WIN_W-1:0]  prod_ff;
   logic [SUM_W-1:0]    sum_ff, rem_ff, root_ff, bit_ff;
   logic [ROOT_W-1:0]   drem_ff;
   logic [QUO_W-1:0]    dnum_ff, quo_ff;
   logic [FRAC_W-1:0]   mag_x_ff, mag_y_ff, mag_z_ff;

   logic [DIFF_W-1:0]   abs_r, abs_u;
   logic [STEP_W-1:0]   mul_a;
   logic [MAG_W-1:0]    mul_b;
   logic [STEP_W+MAG_W-1:0] mul_p;
   logic [VEC_W-1:0]    vmax;
   logic [WIN_W-1:0]    sq_op, div_op;
   logic [SUM_W-1:0]    root_try;
   logic [ROOT_W-1:0]   len;
   logic [NUM_W-1:0]    num;
   logic [ROOT_W:0]     dtry;
   logic                dge;
   logic [ROOT_W-1:0]   drem_nx;
   logic [QUO_W-1:0]    quo_nx;
   logic [FRAC_W-1:0]   quo_sat;

   assign free  = (state_ff == U_IDLE) || (state_ff == U_DONE);
   assign ready = (state_ff == U_DONE);

   // magnitudes of the incoming differences
   assign abs_r = diff_r[DIFF_W-1] ? DIFF_W'(-diff_r) : DIFF_W'(diff_r);
   assign abs_u = diff_u[DIFF_W-1] ? DIFF_W'(-diff_u) : DIFF_W'(diff_u);

   // shared step multiplier
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    begin mul_a = sz_ff; mul_b = dr_mag_ff; end
         2'd1:    begin mul_a = sx_ff; mul_b = du_mag_ff; end
         default: begin mul_a = sx_ff; mul_b = MAG_W'(sz_ff); end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // largest component
   always_comb begin
      vmax = a_ff;
      if (b_ff > vmax) vmax = b_ff;
      if (c_ff > vmax) vmax = c_ff;
   end

   // shared squarer operand
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_op = a_ff[WIN_W-1:0];
         2'd1:    sq_op = b_ff[WIN_W-1:0];
         default: sq_op = c_ff[WIN_W-1:0];
      endcase
   end

   assign root_try = root_ff + bit_ff;
   assign len      = root_ff[ROOT_W-1:0];

   // divider operand and one quotient bit
   always_comb begin
      case (dk_ff)
         2'd0:    div_op = a_ff[WIN_W-1:0];
         2'd1:    div_op = b_ff[WIN_W-1:0];
         default: div_op = c_ff[WIN_W-1:0];
      endcase
   end
   assign num     = {1'b0, div_op, {FRAC_W{1'b0}}} + NUM_W'(len >> 1);
   assign dtry    = {drem_ff, dnum_ff[QUO_W-1]};
   assign dge     = dtry >= {1'b0, len};
   assign drem_nx = dge ? ROOT_W'(dtry - {1'b0, len}) : dtry[ROOT_W-1:0];
   assign quo_nx  = {quo_ff[QUO_W-2:0], dge};
   assign quo_sat = (quo_nx > QUO_W'(32767)) ? FRAC_W'(32767) : quo_nx[FRAC_W-1:0];

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= U_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         U_IDLE, U_DONE: begin
            if (start) state_in = flat ? U_DONE : U_MUL;
         end
         U_MUL: begin
            if (cnt_ff == 5'd2) state_in = U_SHIFT;
         end
         U_SHIFT: begin
            if (vmax[VEC_W-1:WIN_W-1] == 3'b001) state_in = U_SQUARE;
         end
         U_SQUARE: begin
            if (cnt_ff == 5'd3) state_in = U_ROOT;
         end
         U_ROOT: begin
            if (bit_ff[0]) state_in = U_DSET;
         end
         U_DSET: state_in = U_DIV;
         U_DIV: begin
            if (cnt_ff == 5'd0) state_in = (dk_ff == 2'd2) ? U_DONE : U_DSET;
         end
         default: state_in = U_IDLE;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff) inside
         U_IDLE, U_DONE: begin
            if (start) begin
               dr_mag_ff <= abs_r[MAG_W-1:0];
               du_mag_ff <= abs_u[MAG_W-1:0];
               sx_ff     <= step_x;
               sz_ff     <= step_z;
               neg_x_ff  <= !flat && !diff_r[DIFF_W-1] && (diff_r != '0);
               neg_z_ff  <= !flat && !diff_u[DIFF_W-1] && (diff_u != '0);
               cnt_ff    <= '0;
               mag_x_ff  <= '0;
               mag_y_ff  <= FRAC_W'(32767);
               mag_z_ff  <= '0;
            end
         end
         U_MUL: begin
            case (cnt_ff[1:0])
               2'd0:    a_ff <= VEC_W'(mul_p);
               2'd1:    c_ff <= VEC_W'(mul_p);
               default: b_ff <= {mul_p, 1'b0};
            endcase
            cnt_ff <= cnt_ff + 5'd1;
         end
         U_SHIFT: begin
            // bring the largest component into [2^30, 2^31)
            if (vmax[VEC_W-1:WIN_W-1] == 3'b000) begin
               a_ff <= a_ff << 1;
               b_ff <= b_ff << 1;
               c_ff <= c_ff << 1;
            end else if (vmax[VEC_W-1:WIN_W] != 2'b00) begin
               a_ff <= a_ff >> 1;
               b_ff <= b_ff >> 1;
               c_ff <= c_ff >> 1;
            end else begin
               cnt_ff <= '0;
               sum_ff <= '0;
            end
         end
         U_SQUARE: begin
            // one square per cycle, summed from its register in the next cycle
            prod_ff <= sq_op * sq_op;
            if (cnt_ff != 5'd0) sum_ff <= sum_ff + SUM_W'(prod_ff);
            if (cnt_ff == 5'd3) begin
               rem_ff  <= sum_ff + SUM_W'(prod_ff);
               root_ff <= '0;
               bit_ff  <= SUM_W'(1) << (SUM_W - 2);
            end
            cnt_ff <= cnt_ff + 5'd1;
         end
         U_ROOT: begin
            if (rem_ff >= root_try) begin
               rem_ff  <= rem_ff - root_try;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            dk_ff  <= '0;
         end
         U_DSET: begin
            // rounded numerator, upper part already below the length
            drem_ff <= ROOT_W'(num[NUM_W-1:QUO_W]);
            dnum_ff <= num[QUO_W-1:0];
            quo_ff  <= '0;
            cnt_ff  <= 5'(QUO_W - 1);
         end
         U_DIV: begin
            drem_ff <= drem_nx;
            dnum_ff <= dnum_ff << 1;
            quo_ff  <= quo_nx;
            if (cnt_ff == 5'd0) begin
               case (dk_ff)
                  2'd0:    mag_x_ff <= quo_sat;
                  2'd1:    mag_y_ff <= quo_sat;
                  default: mag_z_ff <= quo_sat;
               endcase
               dk_ff <= dk_ff + 2'd1;
            end else begin
               cnt_ff <= cnt_ff - 5'd1;
            end
         end
         default: ;
      endcase
   end

   // signed results
   assign norm_x = neg_x_ff ? -$signed({1'b0, mag_x_ff}) : $signed({1'b0, mag_x_ff});
   assign norm_y = mag_y_ff;
   assign norm_z = neg_z_ff ? -$signed({1'b0, mag_z_ff}) : $signed({1'b0, mag_z_ff});

endmodule

// File: rtl/hnorm_path.sv
// ----------------------------------------------------------------------------
// hnorm_path
// Datapath: grid counters, the two line stores, neighbour selection, the
// normalizer and the result register.
// ----------------------------------------------------------------------------
module hnorm_path import hnorm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  cfg_type                cfg,
   input  logic [HEIGHT_BITS-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);

   logic signed [HEIGHT_BITS-1:0] mid_mem [STORE_DEPTH];
   logic signed [HEIGHT_BITS-1:0] old_mem [STORE_DEPTH];
   logic signed [HEIGHT_BITS-1:0] mid_rd_ff, old_rd_ff;
   logic signed [HEIGHT_BITS-1:0] h_ff, prev_ff, left_ff;
   logic signed [HEIGHT_BITS-1:0] mid_v_ff, oldx_ff, mxp1_ff, oxm1_ff, mxm2_ff;
   logic [SEG_W-1:0]              col_ff, row_ff;
   logic [63:0]                   tdata_ff;
   logic                          tvalid_ff, tlast_ff, tuser_ff;

   logic [SEG_W-1:0]              w, d;
   logic [ADDR_W-1:0]             mid_addr, old_addr;
   logic signed [HEIGHT_BITS-1:0] hl, hr, hd, s0, s1;
   logic signed [DIFF_W-1:0]      dr, du;
   logic [SEG_W-1:0]              pos_col, pos_row;
   logic [STEP_W-1:0]             sx, sz;
   logic                          norm_free, norm_ready;
   logic signed [NORM_W-1:0]      nx, nz;
   logic [NORM_W-2:0]             ny;

   function automatic logic signed [DIFF_W-1:0] sdiff(
      input logic signed [HEIGHT_BITS-1:0] p,
      input logic signed [HEIGHT_BITS-1:0] q);
      logic signed [DIFF_W-1:0] pe, qe;
      pe = {p[HEIGHT_BITS-1], p};
      qe = {q[HEIGHT_BITS-1], q};
      return pe - qe;
   endfunction

   // zero counts and steps act as one
   assign w  = (cfg.seg_across == '0) ? SEG_W'(1) : cfg.seg_across;
   assign d  = (cfg.seg_down == '0) ? SEG_W'(1) : cfg.seg_down;
   assign sx = (cfg.step_x == '0) ? STEP_W'(1) : cfg.step_x;
   assign sz = (cfg.step_z == '0) ? STEP_W'(1) : cfg.step_z;

   // which normals this item causes
   assign sts.e_below    = (row_ff != '0);
   assign sts.e_left     = (row_ff >= d) && (col_ff != '0);
   assign sts.e_corner   = (row_ff >= d) && (col_ff >= w);
   assign sts.norm_free  = norm_free;
   assign sts.norm_ready = norm_ready;
   assign sts.out_free   = !tvalid_ff || rsp_tready;

   // line store addresses per access step
   always_comb begin
      case (cmd.step)
         STEP_READ_B: begin
            mid_addr = ADDR_W'(col_ff + SEG_W'(1));
            old_addr = ADDR_W'(col_ff - SEG_W'(1));
         end
         STEP_READ_C: begin
            mid_addr = ADDR_W'(col_ff - SEG_W'(2));
            old_addr = ADDR_W'(col_ff);
         end
         default: begin
            mid_addr = ADDR_W'(col_ff);
            old_addr = ADDR_W'(col_ff);
         end
      endcase
   end

   // line stores, registered reads
   always_ff @(posedge clock) begin
      if (cmd.step == STEP_COMMIT) begin
         mid_mem[ADDR_W'(col_ff)] <= h_ff;
         old_mem[ADDR_W'(col_ff)] <= mid_v_ff;
      end
      mid_rd_ff <= mid_mem[mid_addr];
      old_rd_ff <= old_mem[old_addr];
   end

   // capture the neighbours
   always_ff @(posedge clock) begin
      if (cmd.accept) h_ff <= $signed(req_tdata);
      case (cmd.step)
         STEP_READ_B: begin
            mid_v_ff <= mid_rd_ff;
            oldx_ff  <= old_rd_ff;
         end
         STEP_READ_C: begin
            mxp1_ff <= mid_rd_ff;
            oxm1_ff <= old_rd_ff;
         end
         STEP_COMMIT: mxm2_ff <= mid_rd_ff;
         default: ;
      endcase
   end

   // grid position and left-hand history
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         prev_ff <= '0;
         left_ff <= '0;
      end else if (cmd.finish) begin
         prev_ff <= h_ff;
         left_ff <= mid_v_ff;
         if (col_ff >= w) begin
            col_ff <= '0;
            row_ff <= (row_ff >= d) ? '0 : row_ff + SEG_W'(1);
         end else begin
            col_ff <= col_ff + SEG_W'(1);
         end
      end
   end

   // neighbour selection per normal
   always_comb begin
      hl = h_ff; hr = h_ff; hd = h_ff; s0 = h_ff; s1 = h_ff;
      pos_col = col_ff;
      pos_row = row_ff;
      case (cmd.kind)
         KIND_BELOW: begin
            hl = (col_ff != '0) ? left_ff : mid_v_ff;
            hr = (col_ff < w) ? mxp1_ff : mid_v_ff;
            hd = (row_ff > SEG_W'(1)) ? oldx_ff : mid_v_ff;
            s0 = hr;
            s1 = h_ff;
            pos_row = row_ff - SEG_W'(1);
         end
         KIND_LEFT: begin
            hl = (col_ff > SEG_W'(1)) ? mxm2_ff : prev_ff;
            hd = oxm1_ff;
            s1 = prev_ff;
            pos_col = col_ff - SEG_W'(1);
         end
         default: begin
            hl = (col_ff != '0) ? prev_ff : h_ff;
            hd = mid_v_ff;
         end
      endcase
      dr = sdiff(s0, hl);
      du = sdiff(s1, hd);
   end

   hnorm_unit u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .flat   (cfg.flat),
      .diff_r (dr),
      .diff_u (du),
      .step_x (sx),
      .step_z (sz),
      .free   (norm_free),
      .ready  (norm_ready),
      .norm_x (nx),
      .norm_y (ny),
      .norm_z (nz)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         tdata_ff <= {1'b0, pos_row, pos_col, nz, ny, nx};
         tlast_ff <= cmd.last;
         tuser_ff <= (cmd.kind == KIND_CORNER);
      end
   end

   assign rsp_tvalid = tvalid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tlast  = tlast_ff;
   assign rsp_tuser  = tuser_ff;

endmodule

// File: rtl/hnorm_ctrl.sv
// ----------------------------------------------------------------------------
// hnorm_ctrl
// Controller: takes one sample, sequences the line store accesses, then runs
// the normalizer once for each normal the sample causes.
// ----------------------------------------------------------------------------
`include "heightfield_normal_generator_unit_assert.svh"

module hnorm_ctrl import hnorm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_RDA    = 8'b0000_0010,
      S_RDB    = 8'b0000_0100,
      S_RDC    = 8'b0000_1000,
      S_COMMIT = 8'b0001_0000,
      S_RUN    = 8'b0010_0000,
      S_WAIT   = 8'b0100_0000,
      S_FIN    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      any_first, more;
   kind_type  first_kind, next_kind;

   // first and following normal of this item
   always_comb begin
      any_first  = sts.e_below | sts.e_left | sts.e_corner;
      first_kind = sts.e_below ? KIND_BELOW : (sts.e_left ? KIND_LEFT : KIND_CORNER);
      case (kind_ff)
         KIND_BELOW: begin
            more      = sts.e_left | sts.e_corner;
            next_kind = sts.e_left ? KIND_LEFT : KIND_CORNER;
         end
         KIND_LEFT: begin
            more      = sts.e_corner;
            next_kind = KIND_CORNER;
         end
         default: begin
            more      = 1'b0;
            next_kind = KIND_CORNER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_BELOW;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      req_tready   = 1'b0;
      cmd.accept   = 1'b0;
      cmd.step     = STEP_NONE;
      cmd.start    = 1'b0;
      cmd.kind     = kind_ff;
      cmd.load_out = 1'b0;
      cmd.last     = !more;
      cmd.finish   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_RDA;
            end
         end
         S_RDA: begin
            cmd.step = STEP_READ_A;
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.step = STEP_READ_B;
            state_in = S_RDC;
         end
         S_RDC: begin
            cmd.step = STEP_READ_C;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.step = STEP_COMMIT;
            kind_in  = first_kind;
            state_in = any_first ? S_RUN : S_FIN;
         end
         S_RUN: begin
            cmd.start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (sts.norm_ready && sts.out_free) begin
               cmd.load_out = 1'b1;
               kind_in      = more ? next_kind : kind_ff;
               state_in     = more ? S_RUN : S_FIN;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // checks
   `HNORM_ASSERT_IMP(a_start_free, clock, reset, cmd.start, sts.norm_free)
   `HNORM_ASSERT_IMP(a_load_free, clock, reset, cmd.load_out, sts.out_free && sts.norm_ready)
   `HNORM_ASSERT_NXT(a_start_waits, clock, reset, cmd.start, state_ff == S_WAIT)
   `HNORM_ASSERT_IMP(a_no_accept_busy, clock, reset, cmd.accept, !sts.norm_ready || req_tready)

endmodule
